/* design/mmf_pkg.sv */
// ============================================================================
// mmf_pkg - shared constants for the moving median filter
// Field widths, register reset values and stream packing sizes.
// ============================================================================
`default_nettype none

package mmf_pkg;

    // sample and median width, two's complement
    localparam int SAMPLE_W = 64;

    // window length register, fill count and samples held
    localparam int CNT_W = 5;

    // default ring depth
    localparam int MAX_WINDOW_DEF = 16;

    // window length after reset
    localparam logic [CNT_W-1:0] LENGTH_RESET = 5'd10;

    // output tdata: median, samples held, zero fill to whole bytes
    localparam int OUT_TDATA_W = ((SAMPLE_W + CNT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

/* design/mmf_ram.sv */
// ============================================================================
// mmf_ram - generic simple dual-port RAM
// One write port, one read port, registered read data. A read and a write
// of the same address in one cycle return the old contents (read first).
// ============================================================================
`default_nettype none

module mmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write and registered read in one process: old data on collision
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* design/mmf_mean.sv */
// ============================================================================
// mmf_mean - mean of two signed samples, truncated toward zero
// Registers the 65-bit sum, then halves it with a round-toward-zero fixup.
// ============================================================================
`default_nettype none

module mmf_mean (
    input  logic                         clk,
    input  logic                         load,
    input  logic [mmf_pkg::SAMPLE_W-1:0] a,
    input  logic [mmf_pkg::SAMPLE_W-1:0] b,
    output logic [mmf_pkg::SAMPLE_W-1:0] result
);

    import mmf_pkg::*;

    logic [SAMPLE_W:0] sum_reg;
    logic [SAMPLE_W:0] sum_next;
    logic              neg_odd;

    // sign-extend both operands so the sum never overflows
    assign sum_next = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};

    // hold the sum until the next load
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg <= sum_next;
        end
    end

    // floor halving, bump a negative odd sum up toward zero
    assign neg_odd = sum_reg[SAMPLE_W] & sum_reg[0];
    assign result  = sum_reg[SAMPLE_W:1] + {{(SAMPLE_W-1){1'b0}}, neg_odd};

endmodule

`default_nettype wire

/* design/moving_median_filter_top.sv */
// Moving median filter: one median result per input item.
// A new item is taken only in the idle state, after the result of the previous
// item has been loaded into the output register, so a result waiting on
// m_tready holds back the input.
// Reset: control clears, window length returns to 10, memories keep contents.
// ============================================================================
// moving_median_filter_top - sliding-window median of 64-bit samples
// Sequencer around a sample ring RAM and a sorted slot list RAM, plus a
// registered mean unit for the even-count median.
// ============================================================================
`default_nettype none

module moving_median_filter_top #(
    parameter int MAX_WINDOW = mmf_pkg::MAX_WINDOW_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write: window_length
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mmf_pkg::CNT_W-1:0]       cfg_data,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mmf_pkg::SAMPLE_W-1:0]    s_tdata,   // [63:0] sample_value
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mmf_pkg::OUT_TDATA_W-1:0] m_tdata    // [63:0] median_value,
                                                       // [68:64] samples_held
);

    import mmf_pkg::*;

    localparam int SLOT_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam int CAP_LEN = (MAX_WINDOW > CNT_MAX) ? CNT_MAX : MAX_WINDOW;
    localparam logic [CNT_W-1:0] CAP_L = CNT_W'(CAP_LEN);
    localparam int PAD_W = OUT_TDATA_W - SAMPLE_W - CNT_W;

    // median fetch steps
    localparam logic [CNT_W-1:0] MED_RD_LO   = 5'd0;
    localparam logic [CNT_W-1:0] MED_RD_HI   = 5'd1;
    localparam logic [CNT_W-1:0] MED_RING_HI = 5'd2;
    localparam logic [CNT_W-1:0] MED_SUM     = 5'd3;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_COUNT  = 6'b000010,
        ST_LIST   = 6'b000100,
        ST_INSERT = 6'b001000,
        ST_MEDIAN = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

    // control registers
    state_t            state_reg,    state_next;
    logic [CNT_W-1:0]  wl_reg,       wl_next;
    logic [CNT_W-1:0]  fc_reg,       fc_next;
    logic [CNT_W-1:0]  ws_reg,       ws_next;
    logic [CNT_W-1:0]  cnt_reg,      cnt_next;
    logic              vld_reg,      vld_next;
    logic [CNT_W-1:0]  idx_reg,      idx_next;
    logic [CNT_W-1:0]  p_reg,        p_next;
    logic              removed_reg,  removed_next;
    logic              full_reg,     full_next;
    logic [CNT_W-1:0]  n_reg,        n_next;
    logic [CNT_W-1:0]  m_reg,        m_next;
    logic [CNT_W-1:0]  slot_reg,     slot_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // payload registers
    logic [SAMPLE_W-1:0] v_reg,      v_next;
    logic [SAMPLE_W-1:0] a_reg,      a_next;
    logic [SAMPLE_W-1:0] median_reg, median_next;
    logic [CNT_W-1:0]    held_reg,   held_next;

    // derived window quantities
    logic [CNT_W-1:0] eff_len;
    logic [CNT_W-1:0] ws_cl;
    logic [CNT_W-1:0] fc_cl;
    logic             win_full;
    logic [CNT_W-1:0] n_new;
    logic [CNT_W-1:0] m_old;
    logic [CNT_W-1:0] ws_adv;
    logic [CNT_W-1:0] lo_pos;
    logic [CNT_W-1:0] hi_pos;
    logic [CNT_W-1:0] red_pos;
    logic [CNT_W-1:0] new_pos;
    logic             slot_match;

    // memory ports
    logic                ring_we;
    logic [SLOT_W-1:0]   ring_waddr;
    logic [SAMPLE_W-1:0] ring_wdata;
    logic [SLOT_W-1:0]   ring_raddr;
    logic [SAMPLE_W-1:0] ring_rdata;
    logic                list_we;
    logic [SLOT_W-1:0]   list_waddr;
    logic [SLOT_W-1:0]   list_wdata;
    logic [SLOT_W-1:0]   list_raddr;
    logic [SLOT_W-1:0]   list_rdata;

    logic                mean_load;
    logic [SAMPLE_W-1:0] mean_res;

    mmf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_we),
        .wr_addr (ring_waddr),
        .wr_data (ring_wdata),
        .rd_addr (ring_raddr),
        .rd_data (ring_rdata)
    );

    mmf_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_WINDOW)
    ) u_list (
        .clk     (clk),
        .wr_en   (list_we),
        .wr_addr (list_waddr),
        .wr_data (list_wdata),
        .rd_addr (list_raddr),
        .rd_data (list_rdata)
    );

    mmf_mean u_mean (
        .clk    (clk),
        .load   (mean_load),
        .a      (a_reg),
        .b      (ring_rdata),
        .result (mean_res)
    );

    // clamp length, ring position and fill count
    always_comb
    begin
        if (wl_reg == '0)
        begin
            eff_len = CNT_W'(1);
        end
        else if (wl_reg > CAP_L)
        begin
            eff_len = CAP_L;
        end
        else
        begin
            eff_len = wl_reg;
        end
        ws_cl    = (ws_reg >= eff_len) ? '0 : ws_reg;
        fc_cl    = (fc_reg > eff_len) ? eff_len : fc_reg;
        win_full = (fc_cl == eff_len);
        n_new    = win_full ? eff_len : fc_cl + 1'b1;
        m_old    = win_full ? eff_len : fc_cl;
        ws_adv   = (ws_cl + 1'b1 == eff_len) ? '0 : ws_cl + 1'b1;
    end

    // middle positions of the sorted list
    assign lo_pos = (n_reg - 1'b1) >> 1;
    assign hi_pos = n_reg >> 1;

    // list rebuild: position after dropping the old slot, then open a gap at p
    assign red_pos    = idx_reg - {{(CNT_W-1){1'b0}}, removed_reg};
    assign new_pos    = (red_pos < p_reg) ? red_pos : red_pos + 1'b1;
    assign slot_match = full_reg && (CNT_W'(list_rdata) == slot_reg);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        wl_next       = wl_reg;
        fc_next       = fc_reg;
        ws_next       = ws_reg;
        cnt_next      = cnt_reg;
        vld_next      = vld_reg;
        idx_next      = idx_reg;
        p_next        = p_reg;
        removed_next  = removed_reg;
        full_next     = full_reg;
        n_next        = n_reg;
        m_next        = m_reg;
        slot_next     = slot_reg;
        m_tvalid_next = m_tvalid_reg;
        v_next        = v_reg;
        a_next        = a_reg;
        median_next   = median_reg;
        held_next     = held_reg;

        ring_we    = 1'b0;
        ring_waddr = SLOT_W'(ws_cl);
        ring_wdata = s_tdata;
        ring_raddr = SLOT_W'(cnt_reg);
        list_we    = 1'b0;
        list_waddr = SLOT_W'(p_reg);
        list_wdata = SLOT_W'(slot_reg);
        list_raddr = SLOT_W'(cnt_reg);
        mean_load  = 1'b0;

        // drop the result once taken
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // length write restarts the window
        if (cfg_valid && cfg_ready)
        begin
            wl_next = cfg_data;
            fc_next = '0;
            ws_next = '0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                // take the item, store it in the ring, commit window state
                if (s_tvalid && s_tready)
                begin
                    v_next     = s_tdata;
                    slot_next  = ws_cl;
                    full_next  = win_full;
                    n_next     = n_new;
                    m_next     = m_old;
                    fc_next    = n_new;
                    ws_next    = ws_adv;
                    ring_we    = 1'b1;
                    cnt_next   = '0;
                    p_next     = '0;
                    vld_next   = 1'b0;
                    state_next = ST_COUNT;
                end
            end

            ST_COUNT:
            begin
                // count other window samples not above the new one
                if (vld_reg && (idx_reg != slot_reg) &&
                    ($signed(ring_rdata) <= $signed(v_reg)))
                begin
                    p_next = p_reg + 1'b1;
                end
                if (cnt_reg != n_reg)
                begin
                    ring_raddr = SLOT_W'(cnt_reg);
                    idx_next   = cnt_reg;
                    vld_next   = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                end
                else
                begin
                    vld_next     = 1'b0;
                    cnt_next     = '0;
                    removed_next = 1'b0;
                    state_next   = ST_LIST;
                end
            end

            ST_LIST:
            begin
                // move each kept slot to its new place, skip the replaced one
                if (vld_reg)
                begin
                    if (slot_match)
                    begin
                        removed_next = 1'b1;
                    end
                    else
                    begin
                        list_we    = 1'b1;
                        list_waddr = SLOT_W'(new_pos);
                        list_wdata = list_rdata;
                    end
                end
                if (cnt_reg != m_reg)
                begin
                    list_raddr = SLOT_W'(cnt_reg);
                    idx_next   = cnt_reg;
                    vld_next   = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                end
                else
                begin
                    vld_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_INSERT;
                end
            end

            ST_INSERT:
            begin
                // drop the new slot into the gap
                list_we    = 1'b1;
                list_waddr = SLOT_W'(p_reg);
                list_wdata = SLOT_W'(slot_reg);
                cnt_next   = '0;
                state_next = ST_MEDIAN;
            end

            ST_MEDIAN:
            begin
                // fetch the two middle slots, then their samples
                cnt_next = cnt_reg + 1'b1;
                case (cnt_reg)
                    MED_RD_LO:
                    begin
                        list_raddr = SLOT_W'(lo_pos);
                    end
                    MED_RD_HI:
                    begin
                        list_raddr = SLOT_W'(hi_pos);
                        ring_raddr = list_rdata;
                    end
                    MED_RING_HI:
                    begin
                        ring_raddr = list_rdata;
                        a_next     = ring_rdata;
                    end
                    MED_SUM:
                    begin
                        mean_load  = 1'b1;
                        state_next = ST_OUT;
                    end
                    default:
                    begin
                        state_next = ST_OUT;
                    end
                endcase
            end

            ST_OUT:
            begin
                // load the output register once it is free
                if (!m_tvalid_reg || m_tready)
                begin
                    median_next   = mean_res;
                    held_next     = n_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            wl_reg       <= LENGTH_RESET;
            fc_reg       <= '0;
            ws_reg       <= '0;
            cnt_reg      <= '0;
            vld_reg      <= 1'b0;
            idx_reg      <= '0;
            p_reg        <= '0;
            removed_reg  <= 1'b0;
            full_reg     <= 1'b0;
            n_reg        <= '0;
            m_reg        <= '0;
            slot_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wl_reg       <= wl_next;
            fc_reg       <= fc_next;
            ws_reg       <= ws_next;
            cnt_reg      <= cnt_next;
            vld_reg      <= vld_next;
            idx_reg      <= idx_next;
            p_reg        <= p_next;
            removed_reg  <= removed_next;
            full_reg     <= full_next;
            n_reg        <= n_next;
            m_reg        <= m_next;
            slot_reg     <= slot_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        a_reg      <= a_next;
        median_reg <= median_next;
        held_reg   <= held_next;
    end

    // hold input items back while a length write is offered
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{PAD_W{1'b0}}, held_reg, median_reg};

    // ring position always inside the current window
    a_ws_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        ws_reg < eff_len)
        else $error("write slot outside window");

    // fill count never exceeds the window
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= eff_len)
        else $error("fill count above window length");

    // insertion point stays inside the list
    a_insert_bound: assert property (@(posedge clk) disable iff (!rst_n)
        p_reg <= n_reg)
        else $error("insertion point beyond list");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while busy");

    // every result covers at least one sample
    a_held_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (held_reg != '0))
        else $error("result with zero samples held");

endmodule

`default_nettype wire

/* verif/moving_median_filter_top_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// moving_median_filter_top_tb - sliding-window median regression
// Drives sample items through the stream input, predicts each median from a
// local copy of the ring and the sorted slot list, and checks every result
// item in order. Covers the reset window length, length extremes, the
// even-count mean and long random runs with random stalls on both sides.
// ============================================================================

module moving_median_filter_top_tb;

    import mmf_pkg::*;

    localparam int DEPTH     = MAX_WINDOW_DEF;
    localparam int CYC_LIMIT = 500000;
    localparam int IDLE_PCT  = 12;
    localparam int SETTLE    = 2 * DEPTH + 10;

    localparam logic [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // expected result item
    typedef struct packed {
        logic [SAMPLE_W-1:0] median;
        logic [CNT_W-1:0]    held;
    } median_exp_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CNT_W-1:0]       cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [SAMPLE_W-1:0]    s_tdata;     // [63:0] sample_value
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;     // [63:0] median_value, [68:64] samples_held

    // predictor state
    logic [SAMPLE_W-1:0] ring [DEPTH];
    logic [3:0]          order [DEPTH];
    logic [CNT_W-1:0]    win_len;
    int                  fill;
    int                  wslot;

    median_exp_t median_q [$];
    bit          no_idle;
    int          fail_count;
    int          samples_sent;
    int          medians_checked;
    int          length_writes;

    moving_median_filter_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // hard stop
    initial
    begin
        repeat (CYC_LIMIT) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // advance the local window by one sample and form the expected median
    function automatic median_exp_t predict_median(input logic [SAMPLE_W-1:0] smp);
        median_exp_t         res;
        int                  len;
        int                  pos;
        logic [SAMPLE_W-1:0] lo_val;
        logic [SAMPLE_W-1:0] hi_val;
        logic signed [SAMPLE_W:0] pair_sum;
        len = int'(win_len);
        if (len < 1)
            len = 1;
        if (len > DEPTH)
            len = DEPTH;
        if (wslot >= len)
            wslot = 0;
        if (fill > len)
            fill = len;
        ring[wslot] = smp;
        if (fill < len)
            fill++;
        else
        begin
            // drop the slot being replaced from the sorted list
            pos = 0;
            while (pos < fill && int'(order[pos]) != wslot)
                pos++;
            for (; pos + 1 < fill; pos++)
                order[pos] = order[pos + 1];
        end
        // insert after any equal values
        pos = fill - 1;
        while (pos > 0 && $signed(ring[order[pos - 1]]) > $signed(smp))
        begin
            order[pos] = order[pos - 1];
            pos--;
        end
        order[pos] = wslot[3:0];
        wslot = (wslot + 1) % len;
        if (fill % 2 == 1)
            res.median = ring[order[fill / 2]];
        else
        begin
            // mean at 65 bits, truncated toward zero
            lo_val   = ring[order[fill / 2 - 1]];
            hi_val   = ring[order[fill / 2]];
            pair_sum = $signed({lo_val[SAMPLE_W-1], lo_val})
                     + $signed({hi_val[SAMPLE_W-1], hi_val});
            pair_sum = pair_sum / 2;
            res.median = pair_sum[SAMPLE_W-1:0];
        end
        res.held = fill[CNT_W-1:0];
        return res;
    endfunction

    // hold ready low at random, about 12 percent of the time, unless no_idle is set
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready = no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // compare each result item with the oldest expectation
    always @(posedge clk)
    begin
        median_exp_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (median_q.size() == 0)
            begin
                $error("unexpected result item: median_value %0d samples_held %0d",
                       $signed(m_tdata[SAMPLE_W-1:0]), m_tdata[SAMPLE_W +: CNT_W]);
                fail_count++;
            end
            else
            begin
                exp_res = median_q.pop_front();
                medians_checked++;
                if (m_tdata[SAMPLE_W-1:0] !== exp_res.median)
                begin
                    $error("median_value: expected %0d, actual %0d",
                           $signed(exp_res.median), $signed(m_tdata[SAMPLE_W-1:0]));
                    fail_count++;
                end
                if (m_tdata[SAMPLE_W +: CNT_W] !== exp_res.held)
                begin
                    $error("samples_held: expected %0d, actual %0d",
                           exp_res.held, m_tdata[SAMPLE_W +: CNT_W]);
                    fail_count++;
                end
            end
        end
    end

    // send one sample item, idling at random before it; returns at a falling edge
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = smp;
        do
            @(posedge clk);
        while (!s_tready);
        median_q.push_back(predict_median(smp));
        samples_sent++;
        @(negedge clk);
    endtask

    // wait for every expected result, then let the block settle
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (median_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // write the window length while the block is idle
    task automatic write_length(input logic [CNT_W-1:0] len);
        drain_results();
        cfg_valid = 1'b1;
        cfg_data  = len;
        do
            @(posedge clk);
        while (!cfg_ready);
        win_len = len;
        fill    = 0;
        wslot   = 0;
        length_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // draw a sample: full range, near zero for ties, near the extremes, mid range
    function automatic logic [SAMPLE_W-1:0] rand_sample();
        int          pick;
        logic [31:0] word;
        pick = $urandom_range(99);
        word = $urandom;
        if (pick < 40)
            return {$urandom, word};
        else if (pick < 70)
            return SAMPLE_W'($urandom_range(16)) - SAMPLE_W'(8);
        else if (pick < 78)
            return S_MAX - SAMPLE_W'($urandom_range(3));
        else if (pick < 86)
            return S_MIN + SAMPLE_W'($urandom_range(3));
        else
            return {{32{word[31]}}, word};
    endfunction

    // reset length of ten: extremes through fill and wrap
    task automatic test_reset_length();
        logic [SAMPLE_W-1:0] pattern [10];
        pattern = '{S_MAX, S_MIN, '0, '1, S_MAX, S_MIN, -64'sd3, 64'sd4, S_MAX, '1};
        foreach (pattern[i])
            send_sample(pattern[i]);
        // wrap past the tenth slot
        send_sample(S_MIN);
        send_sample(64'sd5);
    endtask

    // length zero acts as one, length above the ring acts as the full ring
    task automatic test_length_limits();
        write_length('0);
        send_sample(64'sd17);
        send_sample(-64'sd17);
        write_length('1);
        send_sample(S_MIN);
        send_sample(S_MAX);
        send_sample('0);
    endtask

    // even-count mean: overflow guard and truncation toward zero
    task automatic test_even_mean();
        logic [SAMPLE_W-1:0] pattern [8];
        pattern = '{S_MAX, S_MAX, S_MIN, S_MIN, -64'sd3, -64'sd2, 64'sd3, 64'sd2};
        write_length(CNT_W'(2));
        foreach (pattern[i])
            send_sample(pattern[i]);
    endtask

    // full ring with no idling on either side
    task automatic test_back_to_back();
        write_length(CNT_W'(DEPTH));
        no_idle = 1'b1;
        repeat (150)
            send_sample(rand_sample());
        drain_results();
        no_idle = 1'b0;
    endtask

    // random samples under a sweep of window lengths
    task automatic test_random_windows();
        logic [CNT_W-1:0] lengths [8];
        lengths = '{5'd1, 5'd16, 5'd31, 5'd2, 5'd9, 5'd0, 5'd13, 5'd5};
        foreach (lengths[i])
        begin
            write_length(lengths[i]);
            repeat (100)
                send_sample(rand_sample());
        end
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        no_idle         = 1'b0;
        fail_count      = 0;
        samples_sent    = 0;
        medians_checked = 0;
        length_writes   = 0;
        win_len         = LENGTH_RESET;
        fill            = 0;
        wslot           = 0;
        foreach (ring[i])
        begin
            ring[i]  = '0;
            order[i] = '0;
        end

        // hold reset low, then release it at a falling edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_length();
        test_length_limits();
        test_even_mean();
        test_back_to_back();
        test_random_windows();
        drain_results();

        if (median_q.size() != 0)
            fail_count++;
        $display("Covered %0d samples and %0d checked medians over %0d window length writes,",
                 samples_sent, medians_checked, length_writes);
        $display("including lengths 0, 1, 2 and 31, extreme values and back-to-back traffic.");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
